FILE: hdl/tdbe_pkg.sv
// Shared types and constants for the tag-delimited block extractor.
// No dependencies; imported by tag_delimited_block_extractor_core.
package tdbe_pkg;

   localparam int MaxTagBytes = 8;
   localparam int CharW       = 8;
   localparam int PatternW    = 64;
   localparam int LenW        = 4;
   localparam int CsrIndexW   = 2;
   localparam int CsrDataW    = 64;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_START_PATTERN     = 2'd0,
      CSR_START_PATTERN_LEN = 2'd1,
      CSR_END_PATTERN       = 2'd2,
      CSR_END_PATTERN_LEN   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_SEEK  = 3'b001,
      PH_BLOCK = 3'b010,
      PH_DONE  = 3'b100
   } phase_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic [CharW-1:0] out_char;
      kind_type         out_kind;
      logic             block_found;
      logic             out_final;
   } result_type;

   function automatic logic [LenW-1:0] sat_len(input logic [LenW-1:0] len,
                                               input logic [LenW-1:0] max_len);
      return (len > max_len) ? max_len : len;
   endfunction

endpackage

FILE: hdl/tag_delimited_block_extractor_core.sv
// Results reach rsp_ registered, via the skid stage while a result still waits.
// Throughput: one byte per cycle; the output register and its skid stage let a byte
// enter while a result still waits, and req_stall rises only once the skid stage is full.
// Reset (synchronous, active high) returns the tag registers to their reset values,
// clears the match window and phase, and empties the output register and skid stage.
// Depends on tdbe_pkg.
module tag_delimited_block_extractor_core #(
   parameter int MAX_TAG_BYTES = tdbe_pkg::MaxTagBytes
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tdbe_pkg::CharW-1:0]     req_in_char,
   input  logic                           req_in_final,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tdbe_pkg::CharW-1:0]     rsp_out_char,
   output logic                           rsp_out_kind,
   output logic                           rsp_block_found,
   output logic                           rsp_out_final,
   input  logic                           csr_write,
   input  logic [tdbe_pkg::CsrIndexW-1:0] csr_index,
   input  logic [tdbe_pkg::CsrDataW-1:0]  csr_data
);
   import tdbe_pkg::*;

   localparam int IdxW = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;
   localparam logic [LenW-1:0] MaxLen = LenW'(MAX_TAG_BYTES);

   logic [PatternW-1:0] start_pattern_ff, end_pattern_ff;
   logic [LenW-1:0]     start_len_ff, end_len_ff;

   phase_type           phase_ff, phase_in;
   logic [CharW-1:0]    recent_ff [MAX_TAG_BYTES];
   logic [CharW-1:0]    recent_in [MAX_TAG_BYTES];
   logic [LenW-1:0]     fill_ff, fill_in;

   logic                rsp_valid_ff, skid_valid_ff;
   result_type          rsp_ff, skid_ff, res;

   logic [LenW-1:0]     ls, le;
   logic                start_hit_l [MAX_TAG_BYTES+1];
   logic                end_hit_l [MAX_TAG_BYTES+1];
   logic                start_match, end_match;
   logic                emit, accept, take, res_valid;
   logic [CharW-1:0]    emit_char;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pattern_ff <= '0;
         start_len_ff     <= LenW'(1);
         end_pattern_ff   <= '0;
         end_len_ff       <= LenW'(1);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_START_PATTERN:     start_pattern_ff <= csr_data;
            CSR_START_PATTERN_LEN: start_len_ff     <= csr_data[LenW-1:0];
            CSR_END_PATTERN:       end_pattern_ff   <= csr_data;
            CSR_END_PATTERN_LEN:   end_len_ff       <= csr_data[LenW-1:0];
            default: ;
         endcase
      end
   end

   assign ls = sat_len(start_len_ff, MaxLen);
   assign le = sat_len(end_len_ff, MaxLen);

   // window compare against each possible tag length
   always_comb begin
      for (int l = 0; l <= MAX_TAG_BYTES; l++) begin
         start_hit_l[l] = 1'b1;
         end_hit_l[l]   = 1'b1;
         for (int k = 0; k < MAX_TAG_BYTES; k++) begin
            if (k < l) begin
               if (recent_ff[l-1-k] != start_pattern_ff[8*k +: 8]) start_hit_l[l] = 1'b0;
               if (recent_ff[l-1-k] != end_pattern_ff[8*k +: 8])   end_hit_l[l]   = 1'b0;
            end
         end
      end
      start_match = 1'b0;
      end_match   = 1'b0;
      for (int l = 0; l <= MAX_TAG_BYTES; l++) begin
         if (ls == LenW'(l)) start_match = start_hit_l[l];
         if (le == LenW'(l)) end_match   = end_hit_l[l];
      end
      start_match = start_match && (fill_ff >= ls);
      end_match   = end_match && (fill_ff >= le);
   end

   assign emit_char = recent_ff[IdxW'(le - LenW'(1))];

   assign take   = rsp_valid_ff && !rsp_stall;
   assign accept = req_valid && !skid_valid_ff;

   // next window state and result
   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      recent_in = recent_ff;
      emit      = 1'b0;
      case (phase_ff)
         PH_SEEK: begin
            if (start_match) begin
               phase_in = PH_BLOCK;
               fill_in  = '0;
            end else begin
               recent_in[0] = req_in_char;
               for (int i = 1; i < MAX_TAG_BYTES; i++) recent_in[i] = recent_ff[i-1];
               if (fill_ff < MaxLen) fill_in = fill_ff + LenW'(1);
            end
         end
         PH_BLOCK: begin
            if (end_match) begin
               phase_in = PH_DONE;
            end else begin
               recent_in[0] = req_in_char;
               for (int i = 1; i < MAX_TAG_BYTES; i++) recent_in[i] = recent_ff[i-1];
               if (fill_ff >= le) begin
                  emit    = 1'b1;
                  fill_in = le;
               end else begin
                  fill_in = fill_ff + LenW'(1);
               end
            end
         end
         PH_DONE: ;
         default: phase_in = PH_SEEK;
      endcase

      res.out_char    = emit_char;
      res.out_kind    = KIND_DATA;
      res.block_found = 1'b0;
      res.out_final   = 1'b0;
      if (req_in_final) begin
         res.out_char    = '0;
         res.out_kind    = KIND_STATUS;
         res.block_found = (phase_in == PH_DONE);
         res.out_final   = 1'b1;
         phase_in        = PH_SEEK;
         fill_in         = '0;
         for (int i = 0; i < MAX_TAG_BYTES; i++) recent_in[i] = '0;
      end
      res_valid = accept && (req_in_final || emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         fill_ff  <= '0;
         for (int i = 0; i < MAX_TAG_BYTES; i++) recent_ff[i] <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         fill_ff   <= fill_in;
         recent_ff <= recent_in;
      end
   end

   // output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff && take) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_ff <= res_valid;
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && take) begin
         rsp_ff <= skid_ff;
      end else if (!rsp_valid_ff || take) begin
         rsp_ff <= res;
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_ff.out_char;
   assign rsp_out_kind    = rsp_ff.out_kind;
   assign rsp_block_found = rsp_ff.block_found;
   assign rsp_out_final   = rsp_ff.out_final;

endmodule
